// ===== rtl/core/radix_integer_to_ascii_unit_defines.svh =====
// Assertion macros shared by the radix integer-to-ASCII unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define RITOA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the following cycle.
`define RITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ritoa_pkg.sv =====
// Package for the radix integer-to-ASCII unit: constants, shared types, digit encoder.
// No dependencies.
package ritoa_pkg;

    localparam int DefValueWidth   = 32;
    localparam int RadixWidth      = 5;
    localparam int OffsetWidth     = 8;
    localparam int CharWidth       = 8;
    localparam int DivBitsPerCycle = 8;
    localparam int CmdQDepth       = 2;
    localparam int OutQDepth       = 4;

    localparam logic [RadixWidth-1:0] RadixMin    = 5'd2;
    localparam logic [RadixWidth-1:0] RadixMax    = 5'd16;
    localparam logic [3:0]            DecimalBase = 4'd10;
    localparam logic [CharWidth-1:0]  AsciiZero   = 8'h30;
    localparam logic [CharWidth-1:0]  AsciiMinus  = 8'h2D;
    localparam logic [CharWidth-1:0]  LetterBias  = 8'd39;
    localparam logic [CharWidth-1:0]  InvalidChar = 8'h00;

    // Classified job handed from the front to the back
    typedef struct packed {
        logic                   neg;
        logic                   invalid;
        logic [RadixWidth-1:0]  radix;
        logic [OffsetWidth-1:0] offset;
    } t_cmd;

    // One output character transaction
    typedef struct packed {
        logic [CharWidth-1:0] character;
        logic                 last;
        logic                 invalid;
    } t_char;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_EMIT
    } t_back_state;

    // Digit value to ASCII; letters wrap modulo 256
    function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] digit,
                                                        input logic [OffsetWidth-1:0] offset);
        logic [CharWidth-1:0] wide_digit;
        wide_digit = {4'd0, digit};
        if (digit >= DecimalBase) begin
            return wide_digit + offset + LetterBias;
        end
        return AsciiZero + wide_digit;
    endfunction

endpackage

// ===== rtl/core/ritoa_front.sv =====
// Front end: accepts input transactions, checks the radix, takes the magnitude.
// Depends on ritoa_pkg.
module ritoa_front #(
    parameter int VALUE_WIDTH = ritoa_pkg::DefValueWidth
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [VALUE_WIDTH-1:0]               i_value,
    input  logic                                 i_is_signed,
    input  logic [ritoa_pkg::RadixWidth-1:0]     i_radix,
    input  logic [ritoa_pkg::OffsetWidth-1:0]    i_letter_offset,
    output logic                                 o_q_push,
    output ritoa_pkg::t_cmd                      o_q_cmd,
    output logic [VALUE_WIDTH-1:0]               o_q_mag,
    input  logic                                 i_q_full
);

    logic                   r_vld;
    logic                   n_vld;
    ritoa_pkg::t_cmd        r_cmd;
    ritoa_pkg::t_cmd        n_cmd;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic                   accept;

    // Stage holds one classified job until the command queue takes it
    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_cmd  = r_cmd;
    assign o_q_mag  = r_mag;

    // Classification: radix range, sign, magnitude
    always_comb begin
        n_cmd.invalid = (i_radix < ritoa_pkg::RadixMin) || (i_radix > ritoa_pkg::RadixMax);
        n_cmd.neg     = i_is_signed && i_value[VALUE_WIDTH-1];
        n_cmd.radix   = i_radix;
        n_cmd.offset  = i_letter_offset;
        n_mag         = n_cmd.neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;
    end

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
            r_mag <= n_mag;
        end
    end

endmodule

// ===== rtl/core/ritoa_cmdq.sv =====
// Short command queue between the front end and the conversion engine.
// Depends on ritoa_pkg.
module ritoa_cmdq #(
    parameter int VALUE_WIDTH = ritoa_pkg::DefValueWidth
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ritoa_pkg::t_cmd        i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output ritoa_pkg::t_cmd        o_cmd,
    output logic [VALUE_WIDTH-1:0] o_mag
);

    localparam int PtrWidth = $clog2(ritoa_pkg::CmdQDepth);
    localparam int CntWidth = $clog2(ritoa_pkg::CmdQDepth + 1);

    ritoa_pkg::t_cmd        r_cmd [ritoa_pkg::CmdQDepth];
    logic [VALUE_WIDTH-1:0] r_mag [ritoa_pkg::CmdQDepth];
    logic [PtrWidth-1:0]    r_wr_ptr;
    logic [PtrWidth-1:0]    r_rd_ptr;
    logic [CntWidth-1:0]    r_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_cnt == CntWidth'(ritoa_pkg::CmdQDepth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_mag   = r_mag[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PtrWidth'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrWidth'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntWidth'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntWidth'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cmd[r_wr_ptr] <= i_cmd;
            r_mag[r_wr_ptr] <= i_mag;
        end
    end

endmodule

// ===== rtl/core/ritoa_back.sv =====
// Conversion engine: byte-per-cycle radix divider, digit stack, output queue.
// Depends on ritoa_pkg and radix_integer_to_ascii_unit_defines.svh.
`include "radix_integer_to_ascii_unit_defines.svh"

module ritoa_back #(
    parameter int VALUE_WIDTH = ritoa_pkg::DefValueWidth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  ritoa_pkg::t_cmd                     i_q_cmd,
    input  logic [VALUE_WIDTH-1:0]              i_q_mag,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [ritoa_pkg::CharWidth-1:0]     o_character,
    output logic                                o_last,
    output logic                                o_invalid
);

    localparam int ByteBits   = ritoa_pkg::DivBitsPerCycle;
    localparam int NumSteps   = (VALUE_WIDTH + ByteBits - 1) / ByteBits;
    localparam int WorkWidth  = NumSteps * ByteBits;
    localparam int StepWidth  = $clog2(NumSteps + 1);
    localparam int StackDepth = VALUE_WIDTH + 1;
    localparam int AddrWidth  = $clog2(StackDepth);
    localparam int CntWidth   = $clog2(StackDepth + 1);
    localparam int OqPtrWidth = $clog2(ritoa_pkg::OutQDepth);
    localparam int OqCntWidth = $clog2(ritoa_pkg::OutQDepth + 1);

    ritoa_pkg::t_back_state              r_state;
    ritoa_pkg::t_back_state              n_state;
    logic [WorkWidth-1:0]                r_work;
    logic [3:0]                          r_rem;
    logic [StepWidth-1:0]                r_step;
    logic [CntWidth-1:0]                 r_cnt;
    logic [ritoa_pkg::RadixWidth-1:0]    r_radix;
    logic [ritoa_pkg::OffsetWidth-1:0]   r_offs;
    logic                                r_neg;
    logic                                r_inv;

    logic [ritoa_pkg::CharWidth-1:0]     r_stack [StackDepth];
    logic                                st_we;
    logic [AddrWidth-1:0]                st_waddr;
    logic [ritoa_pkg::CharWidth-1:0]     st_wdata;
    logic [AddrWidth-1:0]                rd_addr;
    logic                                rd_en;
    logic                                r_rd_vld;
    logic [ritoa_pkg::CharWidth-1:0]     r_rd_data;
    logic                                r_rd_last;
    logic                                r_rd_inv;

    ritoa_pkg::t_char                    r_oq [ritoa_pkg::OutQDepth];
    logic [OqPtrWidth-1:0]               r_oq_wr;
    logic [OqPtrWidth-1:0]               r_oq_rd;
    logic [OqCntWidth-1:0]               r_oq_cnt;
    logic                                oq_pop;
    logic                                credit;

    logic [3:0]                          d_rem;
    logic [WorkWidth-1:0]                d_quot;
    logic                                last_step;
    logic                                div_done;

    // Divider step: eight restoring bits of the current dividend byte
    always_comb begin
        logic [ritoa_pkg::RadixWidth-1:0] part;
        logic [3:0]                       rem;
        logic [ByteBits-1:0]              in_byte;
        logic [ByteBits-1:0]              q_byte;
        rem     = r_rem;
        in_byte = r_work[WorkWidth-1 -: ByteBits];
        q_byte  = '0;
        for (int i = ByteBits - 1; i >= 0; i--) begin
            part = {rem, in_byte[i]};
            if (part >= r_radix) begin
                q_byte[i] = 1'b1;
                part      = part - r_radix;
            end
            rem = part[3:0];
        end
        d_rem  = rem;
        d_quot = (r_work << ByteBits) | WorkWidth'(q_byte);
    end

    assign last_step = (r_step == StepWidth'(NumSteps - 1));
    assign div_done  = last_step && (d_quot == '0);
    assign rd_addr   = AddrWidth'(r_cnt - CntWidth'(1));
    assign credit    = (({1'b0, r_oq_cnt} + (OqCntWidth + 1)'(r_rd_vld))
                        < (OqCntWidth + 1)'(ritoa_pkg::OutQDepth));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ritoa_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_cmd.invalid ? ritoa_pkg::BK_EMIT : ritoa_pkg::BK_DIV;
                end
            end
            ritoa_pkg::BK_DIV: begin
                if (div_done) begin
                    n_state = r_neg ? ritoa_pkg::BK_SIGN : ritoa_pkg::BK_EMIT;
                end
            end
            ritoa_pkg::BK_SIGN: begin
                n_state = ritoa_pkg::BK_EMIT;
            end
            ritoa_pkg::BK_EMIT: begin
                if (r_cnt == '0) begin
                    n_state = ritoa_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ritoa_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, stack write, stack read
    always_comb begin
        o_q_pop  = 1'b0;
        st_we    = 1'b0;
        st_waddr = r_cnt[AddrWidth-1:0];
        st_wdata = ritoa_pkg::InvalidChar;
        rd_en    = 1'b0;
        case (r_state)
            ritoa_pkg::BK_IDLE: begin
                o_q_pop = !i_q_empty;
                if (!i_q_empty && i_q_cmd.invalid) begin
                    st_we    = 1'b1;
                    st_waddr = '0;
                end
            end
            ritoa_pkg::BK_DIV: begin
                if (last_step) begin
                    st_we    = 1'b1;
                    st_wdata = ritoa_pkg::digit_char(d_rem, r_offs);
                end
            end
            ritoa_pkg::BK_SIGN: begin
                st_we    = 1'b1;
                st_wdata = ritoa_pkg::AsciiMinus;
            end
            ritoa_pkg::BK_EMIT: begin
                rd_en = (r_cnt != '0) && credit;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ritoa_pkg::BK_IDLE;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (o_q_pop) begin
                r_cnt <= i_q_cmd.invalid ? CntWidth'(1) : '0;
            end else if (st_we) begin
                r_cnt <= r_cnt + CntWidth'(1);
            end else if (rd_en) begin
                r_cnt <= r_cnt - CntWidth'(1);
            end
        end
    end

    // Job and divider registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_work  <= WorkWidth'(i_q_mag);
            r_rem   <= '0;
            r_step  <= '0;
            r_radix <= i_q_cmd.radix;
            r_offs  <= i_q_cmd.offset;
            r_neg   <= i_q_cmd.neg;
            r_inv   <= i_q_cmd.invalid;
        end else if (r_state == ritoa_pkg::BK_DIV) begin
            r_work <= d_quot;
            r_rem  <= last_step ? 4'd0 : d_rem;
            r_step <= last_step ? '0 : r_step + StepWidth'(1);
        end
    end

    // Digit stack, least significant digit at the bottom
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack[st_waddr] <= st_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_stack[rd_addr];
            r_rd_last <= (r_cnt == CntWidth'(1));
            r_rd_inv  <= r_inv;
        end
    end

    // Output queue
    assign o_empty     = (r_oq_cnt == '0);
    assign oq_pop      = i_pop && !o_empty;
    assign o_character = r_oq[r_oq_rd].character;
    assign o_last      = r_oq[r_oq_rd].last;
    assign o_invalid   = r_oq[r_oq_rd].invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_oq_wr <= r_oq_wr + OqPtrWidth'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OqPtrWidth'(1);
            end
            if (r_rd_vld && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + OqCntWidth'(1);
            end else if (oq_pop && !r_rd_vld) begin
                r_oq_cnt <= r_oq_cnt - OqCntWidth'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_oq[r_oq_wr] <= '{character: r_rd_data, last: r_rd_last, invalid: r_rd_inv};
        end
    end

    // Checks
    `RITOA_ASSERT_IMPLIES(a_oq_no_overflow, i_clk, i_rst_n, r_rd_vld, (r_oq_cnt != OqCntWidth'(ritoa_pkg::OutQDepth)), "output queue overflow")
    `RITOA_ASSERT_IMPLIES(a_rem_below_radix, i_clk, i_rst_n, (r_state == ritoa_pkg::BK_DIV), (5'(r_rem) < r_radix), "partial remainder not below radix")
    `RITOA_ASSERT_IMPLIES(a_stack_bound, i_clk, i_rst_n, 1'b1, (r_cnt <= CntWidth'(StackDepth)), "digit stack overrun")
    `RITOA_ASSERT_NEXT(a_emit_drains, i_clk, i_rst_n, ((r_state == ritoa_pkg::BK_EMIT) && (r_cnt != '0)), (r_state == ritoa_pkg::BK_EMIT), "left emit with characters pending")

endmodule

// ===== rtl/core/radix_integer_to_ascii_unit.sv =====
// Channel   Handshake           Payload
// input     i_push / o_full     i_value, i_is_signed, i_radix, i_letter_offset
// result    o_empty / i_pop     o_character, o_last, o_invalid
//
// The engine pops a job, runs the divider loop, eight quotient bits per cycle, once per
// digit, stacks a minus sign for a negative value, and then sends characters one per cycle
// while the output queue has room. An invalid radix skips the divider and yields one
// flagged character. Reset is synchronous; no memory clearing pass.
// Input stalls once the front stage and the 2-entry command queue are full; results wait
// in a 4-entry output queue, and the engine pauses its reads while that queue lacks room.
// Top level of the radix integer-to-ASCII unit; depends on ritoa_pkg, ritoa_front,
// ritoa_cmdq and ritoa_back.
module radix_integer_to_ascii_unit #(
    parameter int VALUE_WIDTH = ritoa_pkg::DefValueWidth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [VALUE_WIDTH-1:0]              i_value,
    input  logic                                i_is_signed,
    input  logic [ritoa_pkg::RadixWidth-1:0]    i_radix,
    input  logic [ritoa_pkg::OffsetWidth-1:0]   i_letter_offset,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [ritoa_pkg::CharWidth-1:0]     o_character,
    output logic                                o_last,
    output logic                                o_invalid
);

    logic                   fq_push;
    logic                   fq_full;
    ritoa_pkg::t_cmd        fq_cmd;
    logic [VALUE_WIDTH-1:0] fq_mag;
    logic                   qb_empty;
    logic                   qb_pop;
    ritoa_pkg::t_cmd        qb_cmd;
    logic [VALUE_WIDTH-1:0] qb_mag;

    ritoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_value         (i_value),
        .i_is_signed     (i_is_signed),
        .i_radix         (i_radix),
        .i_letter_offset (i_letter_offset),
        .o_q_push        (fq_push),
        .o_q_cmd         (fq_cmd),
        .o_q_mag         (fq_mag),
        .i_q_full        (fq_full)
    );

    ritoa_cmdq #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_cmd   (fq_cmd),
        .i_mag   (fq_mag),
        .o_full  (fq_full),
        .i_pop   (qb_pop),
        .o_empty (qb_empty),
        .o_cmd   (qb_cmd),
        .o_mag   (qb_mag)
    );

    ritoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (qb_empty),
        .o_q_pop     (qb_pop),
        .i_q_cmd     (qb_cmd),
        .i_q_mag     (qb_mag),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_character (o_character),
        .o_last      (o_last),
        .o_invalid   (o_invalid)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for radix_integer_to_ascii_unit: directed and random conversions,
// each checked character by character against an in-bench digit predictor.
// Depends on ritoa_pkg and the radix_integer_to_ascii_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = ritoa_pkg::DefValueWidth;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no transaction before giving up
    localparam int DRAIN_WAIT  = 200;    // extra wait once all expected results have been seen
    localparam int RANDOM_ITEMS = 350;

    // Receiver stall modes, rotated by a free-running cycle counter
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_BURSTY,
        RX_SLOW
    } t_rx_mode;

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_push          = 1'b0;
    logic [VW-1:0]                     i_value         = '0;
    logic                              i_is_signed     = 1'b0;
    logic [ritoa_pkg::RadixWidth-1:0]  i_radix         = '0;
    logic [ritoa_pkg::OffsetWidth-1:0] i_letter_offset = '0;
    logic                              i_pop           = 1'b0;
    logic                              o_full;
    logic                              o_empty;
    logic [ritoa_pkg::CharWidth-1:0]   o_character;
    logic                              o_last;
    logic                              o_invalid;

    ritoa_pkg::t_char expected_chars[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    int    burst_left  = 0;
    int    rx_cycle    = 0;
    int    rx_hold     = 0;

    radix_integer_to_ascii_unit #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .i_radix        (i_radix),
        .i_letter_offset(i_letter_offset),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_invalid      (o_invalid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected text of one conversion, appended to the expectation queue
    function automatic void predict_ascii_digits(input logic [VW-1:0] value,
                                                 input logic sgn,
                                                 input logic [ritoa_pkg::RadixWidth-1:0] radix,
                                                 input logic [ritoa_pkg::OffsetWidth-1:0] offs);
        logic [ritoa_pkg::CharWidth-1:0] digits [0:VW];
        logic [VW-1:0]        mag;
        logic [VW-1:0]        digit;
        logic                 neg;
        int                   nd;
        ritoa_pkg::t_char     ch;
        nd = 0;
        if (radix < ritoa_pkg::RadixMin || radix > ritoa_pkg::RadixMax) begin
            ch.character = ritoa_pkg::InvalidChar;
            ch.last      = 1'b1;
            ch.invalid   = 1'b1;
            expected_chars.push_back(ch);
            return;
        end
        neg = sgn && value[VW-1];
        // two's complement negate; the most negative value maps onto itself as unsigned
        mag = neg ? (~value + 1'b1) : value;
        if (mag == '0) begin
            digits[nd] = ritoa_pkg::AsciiZero;
            nd++;
        end
        while (mag != '0) begin
            digit = mag % radix;
            if (digit >= ritoa_pkg::DecimalBase) begin
                digits[nd] = digit[ritoa_pkg::CharWidth-1:0] + offs + ritoa_pkg::LetterBias;
            end else begin
                digits[nd] = ritoa_pkg::AsciiZero + digit[ritoa_pkg::CharWidth-1:0];
            end
            nd++;
            mag = mag / radix;
        end
        if (neg) begin
            ch.character = ritoa_pkg::AsciiMinus;
            ch.last      = 1'b0;
            ch.invalid   = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            ch.character = digits[k];
            ch.last      = (k == 0);
            ch.invalid   = 1'b0;
            expected_chars.push_back(ch);
        end
    endfunction

    // Drive one transaction and hold it until the block takes it
    task automatic send_item(input logic [VW-1:0] value, input logic sgn,
                             input logic [ritoa_pkg::RadixWidth-1:0] radix,
                             input logic [ritoa_pkg::OffsetWidth-1:0] offs);
        @(negedge i_clk);
        i_push          <= 1'b1;
        i_value         <= value;
        i_is_signed     <= sgn;
        i_radix         <= radix;
        i_letter_offset <= offs;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
        predict_ascii_digits(value, sgn, radix, offs);
    endtask

    // Sender pacing: bursts of random length separated by random gaps
    task automatic sender_pace(input int max_gap);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap        = $urandom_range(0, max_gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_push          <= 1'b0;
            i_value         <= VW'({$urandom, $urandom});
            i_letter_offset <= ritoa_pkg::OffsetWidth'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [VW-1:0] shaped_value();
        logic [VW-1:0] raw;
        raw = VW'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: return raw & VW'('hFF);
            1: return raw >> $urandom_range(0, VW - 1);
            2: return ~(raw >> $urandom_range(0, VW - 1));   // small negatives when signed
            3: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(VW-1){1'b0}}};
                    3: return {1'b0, {(VW-1){1'b1}}};
                    default: return VW'(1);
                endcase
            end
            default: return raw;
        endcase
    endfunction

    function automatic logic [ritoa_pkg::RadixWidth-1:0] shaped_radix();
        if ($urandom_range(0, 9) != 0) begin
            return ritoa_pkg::RadixWidth'($urandom_range(ritoa_pkg::RadixMin,
                                                         ritoa_pkg::RadixMax));
        end
        return ritoa_pkg::RadixWidth'($urandom_range(0, 1)
                                      ? $urandom_range(0, ritoa_pkg::RadixMin - 1)
                                      : $urandom_range(ritoa_pkg::RadixMax + 1, 31));
    endfunction

    // Bases outside 2..16 give a single flagged result
    task automatic test_invalid_radix();
        send_item(32'h1234_5678, 1'b0, 5'd0, 8'd48);
        send_item(32'hFFFF_FFFF, 1'b1, 5'd1, 8'd16);
        send_item(32'h0000_0000, 1'b0, 5'd17, 8'd0);
        send_item(32'h8000_0000, 1'b1, 5'd31, 8'd255);
    endtask

    // Zero, all ones, most negative and most positive values
    task automatic test_value_extremes();
        send_item(32'h0000_0000, 1'b0, 5'd10, 8'd48);
        send_item(32'h0000_0000, 1'b1, 5'd2, 8'd48);
        send_item(32'hFFFF_FFFF, 1'b0, 5'd2, 8'd48);
        send_item(32'hFFFF_FFFF, 1'b1, 5'd10, 8'd48);
        send_item(32'h8000_0000, 1'b1, 5'd2, 8'd48);
        send_item(32'h8000_0000, 1'b1, 5'd16, 8'd48);
        send_item(32'h7FFF_FFFF, 1'b1, 5'd10, 8'd48);
        send_item(32'hFFFF_FFFF, 1'b0, 5'd16, 8'd16);
        send_item(32'hFFFF_FFFF, 1'b0, 5'd3, 8'd48);
        send_item(32'h0000_0001, 1'b0, 5'd16, 8'd48);
    endtask

    // Letter digits: lower and upper case, wrap past 255, negative values with letters
    task automatic test_letter_digits();
        send_item(32'hFEDC_BA98, 1'b0, 5'd16, 8'd48);
        send_item(32'hFEDC_BA98, 1'b0, 5'd16, 8'd16);
        send_item(32'hFEDC_BA98, 1'b0, 5'd16, 8'd255);
        send_item(32'h0000_ABCD, 1'b0, 5'd16, 8'd0);
        send_item(-32'sd2748, 1'b1, 5'd16, 8'd48);      // -0xABC keeps its letters
        send_item(32'd10, 1'b0, 5'd11, 8'd255);
        send_item(32'd10, 1'b0, 5'd11, 8'd200);
    endtask

    // Random conversions with bursty sender
    task automatic test_random_conversions();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_item(shaped_value(), 1'($urandom_range(0, 1)), shaped_radix(),
                      ritoa_pkg::OffsetWidth'($urandom));
            // stretches without sender gaps every so often
            sender_pace((n % 100) < 20 ? 0 : 20);
        end
    endtask

    // Receiver stall pattern, independent of the sender
    always @(negedge i_clk) begin
        logic pop_now;
        pop_now = 1'b1;
        case (t_rx_mode'(rx_cycle[9:8]))
            RX_STREAM: pop_now = 1'b1;
            RX_RANDOM: pop_now = 1'($urandom_range(0, 1));
            RX_BURSTY: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    pop_now = 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_hold = $urandom_range(1, 20);
                end
            end
            RX_SLOW:   pop_now = ($urandom_range(0, 3) == 0);
            default:   pop_now = 1'b1;
        endcase
        rx_cycle++;
        i_pop <= pop_now;
    end

    // Compare every popped transaction with the oldest expectation
    always @(posedge i_clk) begin
        ritoa_pkg::t_char want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result: character %h last %b invalid %b",
                         $time, o_character, o_last, o_invalid);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_character !== want.character) begin
                    $display("%0t: character mismatch: expected %h actual %h",
                             $time, want.character, o_character);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, want.last, o_last);
                    error_count++;
                end
                if (o_invalid !== want.invalid) begin
                    $display("%0t: invalid mismatch: expected %b actual %b",
                             $time, want.invalid, o_invalid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_invalid_radix();
        test_value_extremes();
        test_letter_digits();
        test_random_conversions();

        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
